// ===== src/rmq_pkg.sv =====
package rmq_pkg;

  // Default sizes of the base store and the update table
  localparam int DEF_POSITIONS = 1024;
  localparam int DEF_ENTRIES   = 256;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int POS_W   = 10;
  localparam int VALUE_W = 32;
  localparam int TAG_W   = 32;

  // Width that holds any left_pos and the largest POSITIONS
  localparam int POS_EXT_W = 17;

  // Depth of the command queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 2;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   left_pos;
    logic [POS_W-1:0]   right_pos;
    logic [VALUE_W-1:0] value;
    logic [TAG_W-1:0]   cancel_tag;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] max_value;
    logic               overflow;
  } result_t;

  // Classified command: tag is the sequence number for an update,
  // the tag to match for a cancel
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   left_pos;
    logic [POS_W-1:0]   right_pos;
    logic [VALUE_W-1:0] value;
    logic [TAG_W-1:0]   tag;
  } cmd_t;

  // One row of the update table
  typedef struct packed {
    logic               valid;
    logic [POS_W-1:0]   left_pos;
    logic [POS_W-1:0]   right_pos;
    logic [VALUE_W-1:0] value;
    logic [TAG_W-1:0]   tag;
  } entry_t;

endpackage

// ===== src/rmq_ram.sv =====
module rmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word into a register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rmq_front.sv =====
module rmq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  rmq_pkg::item_t item,
  input  logic           clearing,
  input  logic           queue_full,
  output logic           push,
  output rmq_pkg::cmd_t  push_cmd
);

  import rmq_pkg::*;

  logic [TAG_W-1:0] item_count;
  logic [TAG_W-1:0] item_count_next;
  logic             accept;

  // Hold off items during the clearing pass and while the queue is full
  assign item_stall = clearing | queue_full;
  assign accept     = item_valid & ~item_stall;
  assign push       = accept;

  // Number every transfer, whatever its mode
  assign item_count_next = item_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
    end else if (accept) begin
      item_count <= item_count_next;
    end
  end

  // Classify: an update carries its sequence number as tag
  always_comb begin
    push_cmd.mode      = item.mode;
    push_cmd.left_pos  = item.left_pos;
    push_cmd.right_pos = item.right_pos;
    push_cmd.value     = item.value;
    if (item.mode == MODE_UPDATE) begin
      push_cmd.tag = item_count;
    end else begin
      push_cmd.tag = item.cancel_tag;
    end
  end

endmodule

// ===== src/rmq_queue.sv =====
module rmq_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rmq_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          q_valid,
  output rmq_pkg::cmd_t q_cmd,
  input  logic          q_take
);

  import rmq_pkg::*;

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t            slots [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;

  assign full    = (count == (QA_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_take) begin
        count <= count + 1'b1;
      end else if (!push && q_take) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (QA_W+1)'(QUEUE_DEPTH))
    else $error("command queue holds more than its depth");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (count != '0))
    else $error("command taken from an empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !q_take) |=> (count != '0))
    else $error("pushed command lost");

endmodule

// ===== src/rmq_back.sv =====
module rmq_back #(
  parameter int POSITIONS = rmq_pkg::DEF_POSITIONS,
  parameter int ENTRIES   = rmq_pkg::DEF_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  output logic             clearing,
  input  logic             q_valid,
  input  rmq_pkg::cmd_t    q_cmd,
  output logic             q_take,
  output logic             result_valid,
  input  logic             result_stall,
  output rmq_pkg::result_t result
);

  import rmq_pkg::*;

  localparam int BASE_AW   = $clog2(POSITIONS);
  localparam int ENT_W     = $clog2(ENTRIES);
  localparam int CLR_DEPTH = (POSITIONS > ENTRIES) ? POSITIONS : ENTRIES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int ENTRY_BW  = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t             state;
  logic [CLR_W-1:0]   clr_cnt;
  cmd_t               cur;
  logic [ENT_W:0]     issue_cnt;
  logic               pend;
  logic [ENT_W-1:0]   pend_idx;
  logic               base_pend;
  logic               found;
  logic               overflow_seen;
  logic [VALUE_W-1:0] best;
  logic               res_valid;
  result_t            res;

  logic                 base_we;
  logic [BASE_AW-1:0]   base_waddr;
  logic [VALUE_W-1:0]   base_wdata;
  logic [BASE_AW-1:0]   base_raddr;
  logic [VALUE_W-1:0]   base_rdata;
  logic                 ent_we;
  logic [ENT_W-1:0]     ent_waddr;
  entry_t               ent_wdata;
  logic [ENT_W-1:0]     ent_raddr;
  logic [ENTRY_BW-1:0]  ent_rdata;
  entry_t               ent;

  logic [POS_EXT_W-1:0] q_pos_ext;
  logic [POS_EXT_W-1:0] cur_pos_ext;
  logic                 q_in_range;
  logic                 cur_in_range;
  logic                 clr_in_pos;
  logic                 clr_in_ent;
  logic                 clr_last;
  logic                 issue_done;
  logic                 hit;
  logic                 res_free;
  logic                 res_load;

  // Position decode, wide enough for any table size
  assign q_pos_ext    = POS_EXT_W'(q_cmd.left_pos);
  assign cur_pos_ext  = POS_EXT_W'(cur.left_pos);
  assign q_in_range   = q_pos_ext < POS_EXT_W'(POSITIONS);
  assign cur_in_range = cur_pos_ext < POS_EXT_W'(POSITIONS);

  assign clr_in_pos = {1'b0, clr_cnt} < (CLR_W+1)'(POSITIONS);
  assign clr_in_ent = {1'b0, clr_cnt} < (CLR_W+1)'(ENTRIES);
  assign clr_last   = clr_cnt == CLR_W'(CLR_DEPTH - 1);

  assign issue_done = issue_cnt == (ENT_W+1)'(ENTRIES);
  assign ent        = entry_t'(ent_rdata);
  assign hit        = ent.valid && (ent.left_pos <= cur.left_pos)
                      && (cur.left_pos <= ent.right_pos);

  assign clearing     = (state == ST_CLEAR);
  assign q_take       = (state == ST_IDLE) && q_valid;
  assign res_free     = !res_valid || !result_stall;
  assign res_load     = (state == ST_DONE) && (cur.mode == MODE_QUERY) && res_free;
  assign result_valid = res_valid;
  assign result       = res;

  // Drive the memory ports
  always_comb begin
    base_we    = 1'b0;
    base_waddr = q_pos_ext[BASE_AW-1:0];
    base_wdata = q_cmd.value;
    base_raddr = q_pos_ext[BASE_AW-1:0];
    ent_we     = 1'b0;
    ent_waddr  = pend_idx;
    ent_wdata  = ent;
    ent_raddr  = issue_cnt[ENT_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        base_we    = clr_in_pos;
        base_waddr = clr_cnt[BASE_AW-1:0];
        base_wdata = '0;
        ent_we     = clr_in_ent;
        ent_waddr  = clr_cnt[ENT_W-1:0];
        ent_wdata  = '0;
      end
      ST_IDLE: begin
        base_we = q_valid && (q_cmd.mode == MODE_LOAD) && q_in_range;
      end
      ST_SCAN: begin
        if (pend && (cur.mode == MODE_UPDATE) && !ent.valid && !found) begin
          ent_we              = 1'b1;
          ent_wdata.valid     = 1'b1;
          ent_wdata.left_pos  = cur.left_pos;
          ent_wdata.right_pos = cur.right_pos;
          ent_wdata.value     = cur.value;
          ent_wdata.tag       = cur.tag;
        end else if (pend && (cur.mode == MODE_CANCEL) && ent.valid
                     && (ent.tag == cur.tag)) begin
          ent_we          = 1'b1;
          ent_wdata.valid = 1'b0;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  rmq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(POSITIONS)
  ) u_base_ram (
    .clk  (clk),
    .we   (base_we),
    .waddr(base_waddr),
    .wdata(base_wdata),
    .raddr(base_raddr),
    .rdata(base_rdata)
  );

  rmq_ram #(
    .WIDTH(ENTRY_BW),
    .DEPTH(ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  // Sequence the clearing pass and each command
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      issue_cnt     <= '0;
      pend          <= 1'b0;
      base_pend     <= 1'b0;
      found         <= 1'b0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && !result_stall && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_last) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_valid && (q_cmd.mode != MODE_LOAD)) begin
            state     <= ST_SCAN;
            issue_cnt <= '0;
            found     <= 1'b0;
            base_pend <= (q_cmd.mode == MODE_QUERY);
          end
        end
        ST_SCAN: begin
          base_pend <= 1'b0;
          if (issue_done) begin
            pend <= 1'b0;
          end else begin
            pend      <= 1'b1;
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (pend && (cur.mode == MODE_UPDATE) && !ent.valid) begin
            found <= 1'b1;
          end
          if (issue_done && !pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          unique case (cur.mode)
            MODE_UPDATE: begin
              if (!found) begin
                overflow_seen <= 1'b1;
              end
              state <= ST_IDLE;
            end
            MODE_QUERY: begin
              if (res_free) begin
                res_valid <= 1'b1;
                state     <= ST_IDLE;
              end
            end
            MODE_LOAD, MODE_CANCEL: begin
              state <= ST_IDLE;
            end
          endcase
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // Hold the command, the running maximum and the result
  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_cmd;
    end
    if (state == ST_SCAN && !issue_done) begin
      pend_idx <= issue_cnt[ENT_W-1:0];
    end
    if (base_pend) begin
      best <= cur_in_range ? base_rdata : '0;
    end else if ((state == ST_SCAN) && pend && (cur.mode == MODE_QUERY) && hit
                 && (ent.value > best)) begin
      best <= ent.value;
    end
    if (res_load) begin
      res.max_value <= best;
      res.overflow  <= overflow_seen;
    end
  end

  a_base_before_entries: assert property (@(posedge clk) disable iff (rst)
    base_pend |-> !pend)
    else $error("base value and table row arrive in the same cycle");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= (ENT_W+1)'(ENTRIES))
    else $error("scan ran past the end of the table");

  a_found_update_only: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && found) |-> (cur.mode == MODE_UPDATE))
    else $error("free row claimed by a command other than an update");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> !q_take || (state == ST_IDLE))
    else $error("command taken while a scan is running");

endmodule

// ===== src/range_max_update_point_query_core.sv =====
// Channel  Direction  Handshake                  Payload
// item     in         item_valid / item_stall    rmq_pkg::item_t
// result   out        result_valid / result_stall rmq_pkg::result_t
//
// A load is written to the base store in the cycle it leaves the command queue.
// Update, cancel and query each go through a take, one pass over the table
// through its single read port, a drain of the last read and a finishing step.
// After reset the block clears both memories over max(POSITIONS, ENTRIES)
// addresses and stalls items until that pass ends.
// A two-deep command queue lets items arrive while the back end is busy; a
// query holds in its finishing state while an earlier result still waits to leave.
module range_max_update_point_query_core #(
  parameter int POSITIONS = rmq_pkg::DEF_POSITIONS,
  parameter int ENTRIES   = rmq_pkg::DEF_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  rmq_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output rmq_pkg::result_t result
);

  import rmq_pkg::*;

  logic clearing;
  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_take;

  // Accept and number items
  rmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .clearing  (clearing),
    .queue_full(queue_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Decouple front and back
  rmq_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (queue_full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_take  (q_take)
  );

  // Carry out commands against the stores
  rmq_back #(
    .POSITIONS(POSITIONS),
    .ENTRIES  (ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clearing    (clearing),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_take      (q_take),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule
